/* design/tchc_pkg.sv */
// ----------------------------------------------------------------------------
// tchc_pkg: shared constants for the thread count hill climber
// Field widths, register indexes, result codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tchc_pkg;

    // field widths
    localparam int RATE_W     = 32;
    localparam int TEMP_W     = 12;
    localparam int CNT_W      = 9;
    localparam int L3_W       = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TREND_W    = 2;

    // default sizes
    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHYS_CORES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOGICAL_CORES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_L3_CACHE_KB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT    = 3'd3;

    // configuration reset values
    localparam logic [CNT_W-1:0]  PHYS_CORES_RST    = 9'd1;
    localparam logic [CNT_W-1:0]  LOGICAL_CORES_RST = 9'd1;
    localparam logic [L3_W-1:0]   L3_CACHE_KB_RST   = 20'd0;
    localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST    = 12'd850;

    // item opcodes
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;

    // trend action codes
    localparam logic [TREND_W-1:0] TREND_HOLD = 2'd0;
    localparam logic [TREND_W-1:0] TREND_UP   = 2'd1;
    localparam logic [TREND_W-1:0] TREND_DOWN = 2'd2;

    // l3 kilobytes per worker is 2048, a shift by 11
    localparam int CACHE_SHIFT = 11;
    // samples needed before a decision
    localparam int WARM_MIN    = 3;
    localparam logic [CNT_W-1:0] CNT_ONE = 9'd1;

endpackage

`default_nettype wire

/* design/tchc_queue.sv */
// ----------------------------------------------------------------------------
// tchc_queue: decoupling fifo between front and back
// Small register fifo carrying classified requests with a fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module tchc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_push,
    input  wire  [WIDTH-1:0]                i_data,
    input  wire                             i_pop,
    output logic [WIDTH-1:0]                o_data,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_level
);
    import tchc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic             do_pop;

    assign do_pop  = i_pop && (r_lvl != '0);
    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_lvl == '0);
    assign o_level = r_lvl;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_lvl = r_lvl;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH-1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH-1)) ? '0 : r_rd + PTR_W'(1);
        end
        case ({i_push, do_pop})
            2'b10:   n_lvl = r_lvl + LVL_W'(1);
            2'b01:   n_lvl = r_lvl - LVL_W'(1);
            default: n_lvl = r_lvl;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_lvl <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_lvl <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/tchc_front.sv */
// ----------------------------------------------------------------------------
// tchc_front: request intake, rate history and running window sum
// Accepts requests, keeps the sample ring and sum, and queues classified work.
// ----------------------------------------------------------------------------
`default_nettype none

module tchc_front #(
    parameter int HISTORY_DEPTH = tchc_pkg::HISTORY_DEPTH_DEF,
    parameter int QUEUE_DEPTH   = tchc_pkg::QUEUE_DEPTH_DEF,
    parameter int ENTRY_W       = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire                                 i_op,
    input  wire  [tchc_pkg::RATE_W-1:0]         i_hashrate,
    input  wire  [tchc_pkg::TEMP_W-1:0]         i_temperature,
    input  wire  [tchc_pkg::CNT_W-1:0]          i_phys_cores,
    input  wire  [tchc_pkg::L3_W-1:0]           i_l3_cache_kb,
    input  wire  [$clog2(QUEUE_DEPTH+1)-1:0]    i_q_level,
    output logic                                o_push,
    output logic [ENTRY_W-1:0]                  o_push_data
);
    import tchc_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int HELD_W = $clog2(HISTORY_DEPTH+1);
    localparam int SUM_W  = RATE_W + HELD_W;
    localparam int K_W    = HELD_W + 6;
    localparam int LVL_W  = $clog2(QUEUE_DEPTH+1);
    localparam int CRD_W  = LVL_W + 1;

    logic [RATE_W-1:0] r_hist [HISTORY_DEPTH];

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [HELD_W-1:0] r_held, n_held;
    logic [SUM_W-1:0]  r_sum,  n_sum;

    // stage between intake and queue
    logic              r_f_v;
    logic              r_f_op;
    logic [RATE_W-1:0] r_f_rate;
    logic [TEMP_W-1:0] r_f_temp;
    logic [CNT_W-1:0]  r_f_rcnt;
    logic [HELD_W-1:0] r_f_held;
    logic              r_f_sub;
    logic [RATE_W-1:0] r_old;

    logic              accept;
    logic [CNT_W-1:0]  cache_cnt;
    logic [CNT_W-1:0]  min_cnt;
    logic [CNT_W-1:0]  rst_cnt;
    logic              full_ring;
    logic              warm;
    logic [K_W-1:0]    held_k;
    logic [K_W-1:0]    k;

    // keep room in the queue for the item in flight and the one coming in
    assign o_in_stall = (CRD_W'(r_f_v) + CRD_W'(i_q_level)) >= CRD_W'(QUEUE_DEPTH);
    assign accept     = i_in_valid && !o_in_stall;
    assign full_ring  = (r_held == HELD_W'(HISTORY_DEPTH));

    // starting count from cores and cache
    always_comb begin
        cache_cnt = (i_l3_cache_kb != '0) ? i_l3_cache_kb[L3_W-1:CACHE_SHIFT] : i_phys_cores;
        min_cnt   = (i_phys_cores < cache_cnt) ? i_phys_cores : cache_cnt;
        rst_cnt   = (min_cnt == '0) ? CNT_ONE : min_cnt;
    end

    always_comb begin
        n_slot = r_slot;
        n_held = r_held;
        if (accept) begin
            if (i_op == OP_RESTART) begin
                n_slot = '0;
                n_held = '0;
            end else begin
                n_slot = (r_slot == SLOT_W'(HISTORY_DEPTH-1)) ? '0 : r_slot + SLOT_W'(1);
                n_held = full_ring ? r_held : r_held + HELD_W'(1);
            end
        end
    end

    always_comb begin
        if (r_f_op == OP_RESTART) begin
            n_sum = '0;
        end else if (r_f_sub) begin
            n_sum = r_sum + SUM_W'(r_f_rate) - SUM_W'(r_old);
        end else begin
            n_sum = r_sum + SUM_W'(r_f_rate);
        end
    end

    // held * 50 as shifts
    assign held_k = K_W'(r_f_held);
    assign k      = (held_k << 5) + (held_k << 4) + (held_k << 1);
    assign warm   = (r_f_op == OP_RESTART) || (r_f_held < HELD_W'(WARM_MIN));

    assign o_push      = r_f_v;
    assign o_push_data = {r_f_op, warm, r_f_rate, r_f_temp, r_f_rcnt, k, n_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_held <= '0;
            r_sum  <= '0;
            r_f_v  <= 1'b0;
        end else begin
            r_slot <= n_slot;
            r_held <= n_held;
            r_f_v  <= accept;
            if (r_f_v) begin
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_op   <= i_op;
            r_f_rate <= i_hashrate;
            r_f_temp <= i_temperature;
            r_f_rcnt <= rst_cnt;
            r_f_held <= n_held;
            r_f_sub  <= full_ring;
        end
    end

    // read-before-write: the old value leaves the window sum next cycle
    always_ff @(posedge i_clk) begin
        if (accept && (i_op == OP_SAMPLE)) begin
            r_hist[r_slot] <= i_hashrate;
            r_old          <= r_hist[r_slot];
        end
    end

endmodule

`default_nettype wire

/* design/tchc_back.sv */
// ----------------------------------------------------------------------------
// tchc_back: trend decision and count update
// Multiplies out the mean comparison, steps the count and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module tchc_back #(
    parameter int HISTORY_DEPTH = tchc_pkg::HISTORY_DEPTH_DEF,
    parameter int ENTRY_W       = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [ENTRY_W-1:0]                  i_q_data,
    input  wire                                 i_q_empty,
    output logic                                o_pop,
    input  wire  [tchc_pkg::CNT_W-1:0]          i_logical_cores,
    input  wire  [tchc_pkg::TEMP_W-1:0]         i_temp_limit,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [tchc_pkg::CNT_W-1:0]          o_thread_count,
    output logic                                o_warming_up,
    output logic [tchc_pkg::TREND_W-1:0]        o_trend_action,
    output logic                                o_thermal_cut
);
    import tchc_pkg::*;

    localparam int HELD_W = $clog2(HISTORY_DEPTH+1);
    localparam int SUM_W  = RATE_W + HELD_W;
    localparam int K_W    = HELD_W + 6;
    localparam int CMP_W  = SUM_W + 6;

    // entry layout, low to high: sum, k, rcnt, temp, rate, warm, op
    localparam int K_LO    = SUM_W;
    localparam int RCNT_LO = K_LO + K_W;
    localparam int TEMP_LO = RCNT_LO + CNT_W;
    localparam int RATE_LO = TEMP_LO + TEMP_W;
    localparam int WARM_B  = RATE_LO + RATE_W;
    localparam int OP_B    = WARM_B + 1;

    logic [SUM_W-1:0]  q_sum;
    logic [K_W-1:0]    q_k;
    logic [CNT_W-1:0]  q_rcnt;
    logic [TEMP_W-1:0] q_temp;
    logic [RATE_W-1:0] q_rate;
    logic [CMP_W-1:0]  sum_x;

    logic              advance;

    logic              r_b_v;
    logic              r_b_op;
    logic              r_b_warm;
    logic [TEMP_W-1:0] r_b_temp;
    logic [CNT_W-1:0]  r_b_rcnt;
    logic [CMP_W-1:0]  r_b_lhs;
    logic [CMP_W-1:0]  r_b_hi;
    logic [CMP_W-1:0]  r_b_lo;

    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_o_v;
    logic               r_o_warm,  n_warm;
    logic [TREND_W-1:0] r_o_trend, n_trend;
    logic               r_o_cut,   n_cut;
    logic [CNT_W-1:0]   step_cnt;

    assign q_sum  = i_q_data[K_LO-1:0];
    assign q_k    = i_q_data[RCNT_LO-1:K_LO];
    assign q_rcnt = i_q_data[TEMP_LO-1:RCNT_LO];
    assign q_temp = i_q_data[RATE_LO-1:TEMP_LO];
    assign q_rate = i_q_data[WARM_B-1:RATE_LO];
    assign sum_x  = CMP_W'(q_sum);

    assign advance = !r_o_v || !i_out_stall;
    assign o_pop   = advance && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (advance) begin
            r_b_v <= !i_q_empty;
        end
    end

    // rate * held * 50 against sum * 51 and sum * 49
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_op   <= i_q_data[OP_B];
            r_b_warm <= i_q_data[WARM_B];
            r_b_temp <= q_temp;
            r_b_rcnt <= q_rcnt;
            r_b_lhs  <= CMP_W'(q_rate) * CMP_W'(q_k);
            r_b_hi   <= (sum_x << 5) + (sum_x << 4) + (sum_x << 1) + sum_x;
            r_b_lo   <= (sum_x << 5) + (sum_x << 4) + sum_x;
        end
    end

    always_comb begin
        step_cnt = r_count;
        n_trend  = TREND_HOLD;
        n_cut    = 1'b0;
        n_warm   = 1'b0;
        n_count  = r_count;
        if (r_b_op == OP_RESTART) begin
            n_count = r_b_rcnt;
            n_warm  = 1'b1;
        end else if (r_b_warm) begin
            n_warm = 1'b1;
        end else begin
            if (r_b_lhs > r_b_hi) begin
                if (r_count < i_logical_cores) begin
                    step_cnt = r_count + CNT_W'(1);
                    n_trend  = TREND_UP;
                end
            end else if (r_b_lhs < r_b_lo) begin
                if (r_count > CNT_ONE) begin
                    step_cnt = r_count - CNT_W'(1);
                    n_trend  = TREND_DOWN;
                end
            end
            n_count = step_cnt;
            if (($signed(r_b_temp) > $signed(i_temp_limit)) && (step_cnt > CNT_ONE)) begin
                n_count = step_cnt - CNT_W'(1);
                n_cut   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_ONE;
            r_o_v   <= 1'b0;
        end else if (advance) begin
            r_o_v <= r_b_v;
            if (r_b_v) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_b_v) begin
            r_o_warm  <= n_warm;
            r_o_trend <= n_trend;
            r_o_cut   <= n_cut;
        end
    end

    assign o_out_valid    = r_o_v;
    assign o_thread_count = r_count;
    assign o_warming_up   = r_o_warm;
    assign o_trend_action = r_o_trend;
    assign o_thermal_cut  = r_o_cut;

endmodule

`default_nettype wire

/* design/thread_count_hill_climber.sv */
// ----------------------------------------------------------------------------
// thread_count_hill_climber: worker count tuning from hash rate samples
// Top level with configuration registers, front, request queue and back.
// ----------------------------------------------------------------------------
// One request per clock is taken while o_in_stall is low, and one result per
// request is returned, in order. A request passes the front stage (ring write,
// window sum), waits in a QUEUE_DEPTH entry queue, then passes the back (multiply
// stage, count update into the output register): with no stall at the output
// the rate is one request per cycle.
// The queue keeps the input side running while a result waits; the input
// stalls only once the queue and the front stage hold QUEUE_DEPTH requests.
// Configuration writes are taken every cycle; they belong in idle periods.
`default_nettype none

module thread_count_hill_climber #(
    parameter int HISTORY_DEPTH = tchc_pkg::HISTORY_DEPTH_DEF,
    parameter int QUEUE_DEPTH   = tchc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire                                 i_op,
    input  wire  [tchc_pkg::RATE_W-1:0]         i_hashrate,
    input  wire  [tchc_pkg::TEMP_W-1:0]         i_temperature,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [tchc_pkg::CNT_W-1:0]          o_thread_count,
    output logic                                o_warming_up,
    output logic [tchc_pkg::TREND_W-1:0]        o_trend_action,
    output logic                                o_thermal_cut,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [tchc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [tchc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tchc_pkg::*;

    localparam int HELD_W  = $clog2(HISTORY_DEPTH+1);
    localparam int SUM_W   = RATE_W + HELD_W;
    localparam int K_W     = HELD_W + 6;
    localparam int ENTRY_W = 2 + RATE_W + TEMP_W + CNT_W + K_W + SUM_W;
    localparam int LVL_W   = $clog2(QUEUE_DEPTH+1);

    logic [CNT_W-1:0]  r_phys;
    logic [CNT_W-1:0]  r_logical;
    logic [L3_W-1:0]   r_l3;
    logic [TEMP_W-1:0] r_tlimit;

    logic               q_push;
    logic [ENTRY_W-1:0] q_wdata;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_rdata;
    logic               q_empty;
    logic [LVL_W-1:0]   q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phys    <= PHYS_CORES_RST;
            r_logical <= LOGICAL_CORES_RST;
            r_l3      <= L3_CACHE_KB_RST;
            r_tlimit  <= TEMP_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PHYS_CORES:    r_phys    <= i_cfg_data[CNT_W-1:0];
                REG_LOGICAL_CORES: r_logical <= i_cfg_data[CNT_W-1:0];
                REG_L3_CACHE_KB:   r_l3      <= i_cfg_data[L3_W-1:0];
                REG_TEMP_LIMIT:    r_tlimit  <= i_cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    tchc_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .ENTRY_W       (ENTRY_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_hashrate    (i_hashrate),
        .i_temperature (i_temperature),
        .i_phys_cores  (r_phys),
        .i_l3_cache_kb (r_l3),
        .i_q_level     (q_level),
        .o_push        (q_push),
        .o_push_data   (q_wdata)
    );

    tchc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_level (q_level)
    );

    tchc_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .ENTRY_W       (ENTRY_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_data        (q_rdata),
        .i_q_empty       (q_empty),
        .o_pop           (q_pop),
        .i_logical_cores (r_logical),
        .i_temp_limit    (r_tlimit),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_thread_count  (o_thread_count),
        .o_warming_up    (o_warming_up),
        .o_trend_action  (o_trend_action),
        .o_thermal_cut   (o_thermal_cut)
    );

    // queue never takes a request when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_level < LVL_W'(QUEUE_DEPTH)))
        else $error("request queue overflow");

    // count stays at least one on every result
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_thread_count != '0))
        else $error("thread count of zero");

    // no decision during warm-up
    a_warm_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_warming_up) |-> ((o_trend_action == TREND_HOLD) && !o_thermal_cut))
        else $error("action taken while warming up");

    // a request accepted with room downstream shows up as a push next cycle
    a_accept_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> q_push)
        else $error("accepted request not queued");

endmodule

`default_nettype wire
